// ----- rtl/strict_utf8_validator_assert.svh -----
// Assertion macros used by the validator back stage.
`ifndef STRICT_UTF8_VALIDATOR_ASSERT_SVH
`define STRICT_UTF8_VALIDATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SUV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SUV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/suv_pkg.sv -----
// Types and constants shared by the strict UTF-8 validator modules.
package suv_pkg;

  // Byte class as decided by the front stage.
  typedef enum logic [2:0] {
    CLS_ASCII    = 3'd0,
    CLS_CONT     = 3'd1,
    CLS_OVERLONG = 3'd2,
    CLS_LEAD2    = 3'd3,
    CLS_LEAD3    = 3'd4,
    CLS_LEAD4    = 3'd5,
    CLS_BAD      = 3'd6
  } byte_cls_t;

  // One classified beat travelling from front to back.
  typedef struct packed {
    logic      is_end;
    byte_cls_t cls;
    logic [5:0] payload;
  } beat_t;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] CP_MIN3   = 21'h000800;
  localparam logic [CP_W-1:0] CP_SUR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SUR_HI = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MIN4   = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO  = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR = 2'd3;

endpackage

// ----- rtl/suv_front.sv -----
// Front stage: accepts input beats and classifies each byte into a register.
module suv_front
  import suv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_kind,
  input  logic [7:0] in_byte_value,
  output logic       fr_valid,
  output beat_t      fr_beat,
  input  logic       q_full
);

  logic  fr_valid_r, fr_valid_nxt;
  beat_t fr_beat_r, fr_beat_nxt;
  logic  take, move;

  function automatic beat_t classify(input logic kind, input logic [7:0] c);
    beat_t b;
    b.is_end  = kind;
    b.payload = c[5:0];
    if (!c[7]) begin
      b.cls = CLS_ASCII;
    end else if (!c[6]) begin
      b.cls = CLS_CONT;
    end else if (!c[5]) begin
      b.cls     = (c[4:1] == 4'd0) ? CLS_OVERLONG : CLS_LEAD2;
      b.payload = {1'b0, c[4:0]};
    end else if (!c[4]) begin
      b.cls     = CLS_LEAD3;
      b.payload = {2'b00, c[3:0]};
    end else if (!c[3]) begin
      b.cls     = CLS_LEAD4;
      b.payload = {3'b000, c[2:0]};
    end else begin
      b.cls = CLS_BAD;
    end
    return b;
  endfunction

  assign move = fr_valid_r && !q_full;
  assign full = fr_valid_r && q_full;
  assign take = push && !full;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_beat_nxt  = fr_beat_r;
    if (take) begin
      fr_valid_nxt = 1'b1;
      fr_beat_nxt  = classify(in_kind, in_byte_value);
    end else if (move) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_beat_r <= fr_beat_nxt;
  end

  assign fr_valid = fr_valid_r;
  assign fr_beat  = fr_beat_r;

endmodule

// ----- rtl/suv_queue.sv -----
// Short queue of classified beats between the front and back stages.
module suv_queue
  import suv_pkg::*;
#(
  parameter int DEPTH = 4
)
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  beat_t wr_beat,
  output logic  q_full,
  input  logic  rd_en,
  output logic  q_valid,
  output beat_t rd_beat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  beat_t         slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;
  assign rd_beat = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_beat;
    end
  end

endmodule

// ----- rtl/suv_back.sv -----
// Back stage: per-string decoder state and the result register.
module suv_back
  import suv_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  beat_t q_beat,
  output logic  q_rd,
  output logic  empty,
  input  logic  pop,
  output logic  out_is_valid
);

  logic            failed_r, failed_nxt;
  logic [1:0]      pending_r, pending_nxt;
  logic [1:0]      seq_len_r, seq_len_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;
  logic            out_v_r, out_v_nxt;
  logic            res_r, res_nxt;
  logic            slot_free;
  logic [CP_W-1:0] acc_shift;
  logic [1:0]      pending_dec;

  assign slot_free   = !out_v_r || pop;
  assign q_rd        = q_valid && (!q_beat.is_end || slot_free);
  assign acc_shift   = {acc_r[CP_W-7:0], q_beat.payload};
  assign pending_dec = pending_r - 2'd1;

  always_comb begin
    failed_nxt  = failed_r;
    pending_nxt = pending_r;
    seq_len_nxt = seq_len_r;
    acc_nxt     = acc_r;
    out_v_nxt   = out_v_r && !pop;
    res_nxt     = res_r;
    if (q_rd) begin
      if (q_beat.is_end) begin
        out_v_nxt   = 1'b1;
        res_nxt     = !failed_r && (pending_r == 2'd0);
        failed_nxt  = 1'b0;
        pending_nxt = 2'd0;
        seq_len_nxt = SEQ_NONE;
        acc_nxt     = '0;
      end else if (!failed_r) begin
        if (pending_r == 2'd0) begin
          case (q_beat.cls)
            CLS_ASCII: begin
            end
            CLS_LEAD2: begin
              pending_nxt = 2'd1;
              seq_len_nxt = SEQ_TWO;
              acc_nxt     = CP_W'(q_beat.payload);
            end
            CLS_LEAD3: begin
              pending_nxt = 2'd2;
              seq_len_nxt = SEQ_THREE;
              acc_nxt     = CP_W'(q_beat.payload);
            end
            CLS_LEAD4: begin
              pending_nxt = 2'd3;
              seq_len_nxt = SEQ_FOUR;
              acc_nxt     = CP_W'(q_beat.payload);
            end
            default: begin
              failed_nxt = 1'b1;
            end
          endcase
        end else if (q_beat.cls != CLS_CONT) begin
          failed_nxt = 1'b1;
        end else begin
          acc_nxt     = acc_shift;
          pending_nxt = pending_dec;
          if (pending_dec == 2'd0) begin
            // Range checks once the whole code point is in.
            if (seq_len_r == SEQ_THREE) begin
              if (acc_shift < CP_MIN3 ||
                  (acc_shift >= CP_SUR_LO && acc_shift <= CP_SUR_HI)) begin
                failed_nxt = 1'b1;
              end
            end else if (seq_len_r == SEQ_FOUR) begin
              if (acc_shift < CP_MIN4 || acc_shift > CP_MAX) begin
                failed_nxt = 1'b1;
              end
            end
            seq_len_nxt = SEQ_NONE;
            acc_nxt     = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r  <= 1'b0;
      pending_r <= 2'd0;
      seq_len_r <= SEQ_NONE;
      acc_r     <= '0;
      out_v_r   <= 1'b0;
    end else begin
      failed_r  <= failed_nxt;
      pending_r <= pending_nxt;
      seq_len_r <= seq_len_nxt;
      acc_r     <= acc_nxt;
      out_v_r   <= out_v_nxt;
    end
    res_r <= res_nxt;
  end

  assign empty        = !out_v_r;
  assign out_is_valid = res_r;

`include "strict_utf8_validator_assert.svh"

  `SUV_ASSERT_NOW(a_idle_clean, pending_r == 2'd0, seq_len_r == SEQ_NONE && acc_r == '0, "idle decoder holds stale sequence state")
  `SUV_ASSERT_NOW(a_pending_fits, pending_r != 2'd0, pending_r <= seq_len_r, "more continuation bytes pending than the sequence allows")
  `SUV_ASSERT_NEXT(a_fail_sticky, failed_r && !(q_rd && q_beat.is_end), failed_r, "error flag cleared before the end of the string")

endmodule

// ----- rtl/strict_utf8_validator.sv -----
// Top level of the strict UTF-8 validator: front, beat queue and back stage.
//
//   Channel  Ports                           Beat carries
//   -------  ------------------------------  ------------------------------
//   input    push, full, in_kind,            one string byte or an end mark
//            in_byte_value
//   result   pop, empty, out_is_valid        verdict for one ended string
//
// One input beat can be taken every clock cycle while full is low, string bytes
// and end marks alike; the back stage updates the decoder state for each byte.
// An accepted end mark passes through the front register and then the queue,
// after which the back stage loads its verdict into the result register that
// drives the result ports. Reset is synchronous on rst_n
// and clears all control state and the decoder state; no clearing pass is
// needed. When the result register is held, an end mark at the head of the
// queue waits there with the beats behind it, and full rises only once the
// queue and the front register are both occupied.
module strict_utf8_validator
  import suv_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_kind,
  input  logic [7:0] in_byte_value,
  output logic       empty,
  input  logic       pop,
  output logic       out_is_valid
);

  // Front register to queue.
  logic  fr_valid;
  beat_t fr_beat;
  logic  q_full;

  // Queue to back stage.
  logic  q_valid;
  beat_t q_beat;
  logic  q_rd;

  // The front stage classifies each byte as it is taken, so the back stage
  // only sees a class code and the payload bits that matter for it.
  suv_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_kind       (in_kind),
    .in_byte_value (in_byte_value),
    .fr_valid      (fr_valid),
    .fr_beat       (fr_beat),
    .q_full        (q_full)
  );

  // The queue decouples the two sides, so a held verdict does not stop
  // bytes of the next string from being accepted until the queue fills.
  suv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_valid),
    .wr_beat (fr_beat),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .q_valid (q_valid),
    .rd_beat (q_beat)
  );

  // The back stage keeps the decoder state of the open string and the
  // result register that drives the result channel.
  suv_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_beat       (q_beat),
    .q_rd         (q_rd),
    .empty        (empty),
    .pop          (pop),
    .out_is_valid (out_is_valid)
  );

endmodule
